FILE: hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer to ASCII formatter
// Widths, format kinds, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned VALUE_WIDTH = 64;  // value bits used (8..64)
  localparam int unsigned DATA_W      = 64;  // value field width on the port
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CHAR_W      = 8;

  // decimal digits of 2^VALUE_WIDTH-1: floor(VALUE_WIDTH*log10(2))+1
  localparam int unsigned DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned NUM_DIGITS  = DEC_DIGITS;
  localparam int unsigned IDX_W       = $clog2(NUM_DIGITS);
  localparam int unsigned BITCNT_W    = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned POS_W       = 3;
  localparam int unsigned NIL_LEN     = 5;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;  // 'x'
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'

  typedef enum logic [KIND_W-1:0] {
    KIND_SDEC,
    KIND_UDEC,
    KIND_HEX,
    KIND_PTR
  } kind_e;

  typedef enum logic [1:0] {
    SEL_PREFIX,
    SEL_DIGIT,
    SEL_NIL
  } char_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PREFIX,
    ST_DIGIT,
    ST_NIL
  } state_e;

  typedef struct packed {
    logic      load;       // take a new request
    logic      conv_step;  // one shift-add-3 step
    logic      idx_dec;    // move to next lower digit
    logic      emit;       // load output register
    char_sel_e sel;
    logic      emit_last;
    logic      pos_inc;    // next prefix / nil character
  } cmd_t;

  typedef struct packed {
    logic in_nil;       // incoming request is a null pointer
    logic in_hex;       // incoming request needs no decimal conversion
    logic conv_last;    // final conversion step
    logic top_zero;     // current digit is zero
    logic idx_zero;     // current digit is the lowest
    logic need_prefix;  // a prefix character is still due
    logic nil_last;     // current nil character is the final one
    logic out_free;     // output register can take a character
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'h0, d};
    end else begin
      c = 8'h57 + {4'h0, d};  // 'a' - 10
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] nil_char(logic [POS_W-1:0] p);
    logic [CHAR_W-1:0] c;
    case (p)
      3'd0:    c = 8'h28;  // '('
      3'd1:    c = 8'h6E;  // 'n'
      3'd2:    c = 8'h69;  // 'i'
      3'd3:    c = 8'h6C;  // 'l'
      default: c = 8'h29;  // ')'
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl: sequencing state machine of the formatter
// Steps conversion, leading-zero skip, prefix, digits and nil text.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  itoa_pkg::status_t sts_i,
  output itoa_pkg::cmd_t    cmd_o
);
  import itoa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_nil) begin
            state_d = ST_NIL;
          end else if (sts_i.in_hex) begin
            state_d = ST_SKIP;
          end else begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (sts_i.conv_last) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!sts_i.top_zero || sts_i.idx_zero) begin
          state_d = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        if (!sts_i.need_prefix) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free && sts_i.idx_zero) begin
          state_d = ST_IDLE;
        end
      end
      ST_NIL: begin
        if (sts_i.out_free && sts_i.nil_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_DIGIT;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
      end
      ST_SKIP: begin
        cmd_o.idx_dec = sts_i.top_zero && !sts_i.idx_zero;
      end
      ST_PREFIX: begin
        cmd_o.sel = SEL_PREFIX;
        if (sts_i.need_prefix && sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.pos_inc = 1'b1;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = sts_i.idx_zero;
          cmd_o.idx_dec   = !sts_i.idx_zero;
        end
      end
      ST_NIL: begin
        cmd_o.sel = SEL_NIL;
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = sts_i.nil_last;
          cmd_o.pos_inc   = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: hdl/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp: formatter datapath
// Magnitude and digit registers (shift-add-3 conversion), output register.
// ----------------------------------------------------------------------------
module itoa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [itoa_pkg::KIND_W-1:0]   kind_i,
  input  logic [itoa_pkg::DATA_W-1:0]   value_i,
  input  itoa_pkg::cmd_t                cmd_i,
  output itoa_pkg::status_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [itoa_pkg::CHAR_W-1:0]   out_char_o,
  output logic                          out_last_o
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0]         vm;
  logic [VALUE_WIDTH-1:0]         mag;
  logic                           in_neg;
  kind_e                          in_kind;

  logic [VALUE_WIDTH-1:0]         bin_q;
  logic [NUM_DIGITS-1:0][3:0]     bcd_q, bcd_adj;
  logic [NUM_DIGITS*4-1:0]        bcd_flat;
  kind_e                          kind_q;
  logic                           neg_q;
  logic [BITCNT_W-1:0]            bitcnt_q;
  logic [IDX_W-1:0]               idx_q;
  logic [POS_W-1:0]               pos_q;
  logic [3:0]                     cur_digit;

  logic                           out_valid_q;
  logic [CHAR_W-1:0]              out_char_q, out_char_d;
  logic                           out_last_q;

  assign in_kind = kind_e'(kind_i);
  assign vm      = value_i[VALUE_WIDTH-1:0];
  assign in_neg  = (in_kind == KIND_SDEC) && vm[VALUE_WIDTH-1];
  assign mag     = in_neg ? (~vm + 1'b1) : vm;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  assign bcd_flat  = bcd_adj;
  assign cur_digit = bcd_q[idx_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= in_kind;
      neg_q    <= in_neg;
      bin_q    <= mag;
      bitcnt_q <= BITCNT_W'(VALUE_WIDTH);
      pos_q    <= '0;
      if (in_kind == KIND_HEX || in_kind == KIND_PTR) begin
        bcd_q <= (NUM_DIGITS*4)'(vm);
        idx_q <= IDX_W'(HEX_DIGITS - 1);
      end else begin
        bcd_q <= '0;
        idx_q <= IDX_W'(DEC_DIGITS - 1);
      end
    end else begin
      if (cmd_i.conv_step) begin
        bcd_q    <= {bcd_flat[NUM_DIGITS*4-2:0], bin_q[VALUE_WIDTH-1]};
        bin_q    <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
        bitcnt_q <= bitcnt_q - 1'b1;
      end
      if (cmd_i.idx_dec) begin
        idx_q <= idx_q - 1'b1;
      end
      if (cmd_i.pos_inc) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // character mux
  always_comb begin
    case (cmd_i.sel)
      SEL_PREFIX: begin
        if (kind_q == KIND_PTR) begin
          out_char_d = (pos_q == '0) ? CH_ZERO : CH_X;
        end else begin
          out_char_d = CH_MINUS;
        end
      end
      SEL_NIL:    out_char_d = nil_char(pos_q);
      default:    out_char_d = digit_char(cur_digit);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= out_char_d;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign sts_o.in_nil      = (in_kind == KIND_PTR) && (vm == '0);
  assign sts_o.in_hex      = (in_kind == KIND_HEX) || (in_kind == KIND_PTR);
  assign sts_o.conv_last   = (bitcnt_q == BITCNT_W'(1));
  assign sts_o.top_zero    = (cur_digit == 4'd0);
  assign sts_o.idx_zero    = (idx_q == '0);
  assign sts_o.need_prefix = (kind_q == KIND_PTR) ? (pos_q < POS_W'(2))
                                                  : (neg_q && (pos_q == '0));
  assign sts_o.nil_last    = (pos_q == POS_W'(NIL_LEN - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hdl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: streams a value as ASCII decimal or hex text
// Signed/unsigned decimal, lowercase hex, pointer ("0x..." or "(nil)").
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                 | tuser     | tlast
//  --------+-----+-----------------------+-----------+------------------
//  s_axis  | in  | [63:0] value          | [1:0] kind| -
//  m_axis  | out | [7:0]  char_out       | -         | last character
//
// A request is taken only while the block is idle. Decimal kinds run one
// shift-add-3 step per value bit, hex kinds skip that. Leading zero
// digits are then dropped at one digit per cycle (up to 19), and the
// characters leave one at a time through the output register.
// Output stalls hold the sequencer; the last character may still wait in
// the output register while the next request is accepted. Reset is async.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [itoa_pkg::DATA_W-1:0] s_axis_tdata_i,   // [63:0] value
  input  logic [itoa_pkg::KIND_W-1:0] s_axis_tuser_i,   // [1:0] kind
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [itoa_pkg::CHAR_W-1:0] m_axis_tdata_o,   // [7:0] char_out
  output logic                        m_axis_tlast_o
);
  import itoa_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencer: idle -> convert -> skip zeros -> prefix -> digits (or nil)
  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // digit registers, conversion step and output register
  itoa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (s_axis_tuser_i),
    .value_i     (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

FILE: tb/integer_to_ascii_formatter_tb.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb: self-checking bench for the ASCII formatter
// Drives format requests (signed/unsigned decimal, hex, pointer) into the
// stream input, rebuilds the expected text of each accepted request in the
// bench, and compares every character and its end marker as it leaves.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned IDLE_PCT     = 21;
  // After the last character, give the block about one full request time
  // (conversion steps, zero skipping, output) before calling it done.
  localparam int unsigned DRAIN_CYCLES = VALUE_WIDTH + 2 * NUM_DIGITS + 16;
  // Watchdog bound for the whole run: 276 requests with stalls and one long hold.
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  // One expected character of formatted text.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } text_char_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [DATA_W-1:0]   s_axis_tdata_i;   // [63:0] value
  logic [KIND_W-1:0]   s_axis_tuser_i;   // [1:0] kind
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [CHAR_W-1:0]   m_axis_tdata_o;   // [7:0] char_out
  logic                m_axis_tlast_o;

  text_char_t pending_chars[$];   // characters owed by the block, oldest first
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned chars_checked;
  int unsigned requests_by_kind[4];
  int unsigned hold_left;         // receiver hold-off, counted down per cycle
  bit          steady_flow;       // no random idling on either side

  integer_to_ascii_formatter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Rebuild the text of one request and queue its characters.
  function automatic void format_value(kind_e kind, logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] v;
    logic [CHAR_W-1:0] text[$];
    logic [CHAR_W-1:0] digits[$];
    logic [3:0]        nib;
    bit                hex;
    text_char_t        entry;
    mask = {DATA_W{1'b1}} >> (DATA_W - VALUE_WIDTH);
    v    = raw & mask;   // bits above VALUE_WIDTH never count
    hex  = (kind == KIND_HEX) || (kind == KIND_PTR);
    if (kind == KIND_PTR && v == '0) begin
      text = '{"(", "n", "i", "l", ")"};
    end else begin
      // Negative signed: minus sign, then magnitude. Two's complement of the
      // most negative value wraps to itself, which is exactly 2^(W-1).
      if (kind == KIND_SDEC && v[VALUE_WIDTH-1]) begin
        text.push_back(CH_MINUS);
        v = (~v + 1'b1) & mask;
      end
      if (kind == KIND_PTR) begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
      end
      do begin
        if (hex) begin
          nib = v[3:0];
          digits.push_front((nib < 4'd10) ? CH_ZERO + CHAR_W'(nib)
                                          : "a" + CHAR_W'(nib) - 8'd10);
          v = v >> 4;
        end else begin
          digits.push_front(CH_ZERO + CHAR_W'(v % 10));
          v = v / 10;
        end
      end while (v != '0);
      text = {text, digits};
    end
    foreach (text[i]) begin
      entry.ch      = text[i];
      entry.is_last = (i == text.size() - 1);
      pending_chars.push_back(entry);
    end
  endfunction

  // Random value with a random significant length, now and then a power of
  // ten or one below it to hit digit-count boundaries.
  function automatic logic [DATA_W-1:0] random_value();
    logic [DATA_W-1:0] v;
    int unsigned       bits;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) begin
      v = 64'd1;
      repeat ($urandom_range(0, 19)) v = v * 10;
      v = v - $urandom_range(0, 1);
    end else begin
      bits = $urandom_range(0, DATA_W);
      if (bits < DATA_W) v = v & ((64'd1 << bits) - 1);
    end
    return v;
  endfunction

  // Offer one request and hold it until the block takes it. Returns just
  // after the accepting edge with tvalid still high, so a following request
  // continues back to back unless a gap is drawn.
  task automatic send_request(kind_e kind, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = value;
    s_axis_tuser_i  = kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_random_request();
    send_request(kind_e'($urandom_range(0, 3)), random_value());
  endtask

  // Zero, one, the extremes and the sign corner in every kind.
  task automatic test_directed();
    kind_e k;
    for (int i = 0; i < 4; i++) begin
      k = kind_e'(i);
      send_request(k, 64'd0);
      send_request(k, 64'd1);
      send_request(k, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(k, 64'h8000_0000_0000_0000);
    end
    send_request(KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);   // largest positive
    send_request(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFF6);   // -10
    send_request(KIND_UDEC, 64'd9);
    send_request(KIND_UDEC, 64'd10);
    send_request(KIND_UDEC, 64'd10_000_000_000_000_000_000);
    send_request(KIND_HEX,  64'h0123_4567_89AB_CDEF);   // every hex digit
    send_request(KIND_PTR,  64'hFEDC_BA98_7654_3210);
    send_request(KIND_PTR,  64'h10);
  endtask

  // Bulk of the run: random kinds and lengths with random idling.
  task automatic test_random(int unsigned count);
    repeat (count) send_random_request();
  endtask

  // Long stretch at full rate on both sides.
  task automatic test_back_to_back(int unsigned count);
    steady_flow = 1'b1;
    repeat (count) send_random_request();
    steady_flow = 1'b0;
  endtask

  // Receiver holds off for a long stretch while requests keep coming; the
  // output fills and the block must stall its input without losing text.
  task automatic test_output_hold(int unsigned count);
    steady_flow = 1'b1;
    send_random_request();
    hold_left = 300;
    repeat (count - 1) send_random_request();
    steady_flow = 1'b0;
  endtask

  // Receiver: random ready, or held low while a hold-off counts down.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i = 1'b0;
      hold_left       = hold_left - 1;
    end else if (steady_flow) begin
      m_axis_tready_i = 1'b1;
    end else begin
      m_axis_tready_i = ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Predict on each accepted request, check each accepted character.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        format_value(kind_e'(s_axis_tuser_i), s_axis_tdata_i);
        requests_by_kind[s_axis_tuser_i]++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected character: char_out 8'h%02h last %0b",
                 m_axis_tdata_o, m_axis_tlast_o);
          error_count++;
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (m_axis_tdata_o !== want.ch) begin
            $error("char_out mismatch: expected 8'h%02h actual 8'h%02h",
                   want.ch, m_axis_tdata_o);
            error_count++;
          end
          if (m_axis_tlast_o !== want.is_last) begin
            $error("last mismatch: expected %0b actual %0b",
                   want.is_last, m_axis_tlast_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, pending_chars.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_SDEC;
    m_axis_tready_i = 1'b0;
    hold_left       = 0;
    steady_flow     = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    chars_checked   = 0;
    foreach (requests_by_kind[i]) requests_by_kind[i] = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(210);
    test_back_to_back(30);
    test_output_hold(12);

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    // Wait out the owed text, then a full request time for strays.
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      $error("%0d expected characters never arrived", pending_chars.size());
      error_count++;
    end

    $display("covered: %0d signed, %0d unsigned, %0d hex, %0d pointer requests",
             requests_by_kind[KIND_SDEC], requests_by_kind[KIND_UDEC],
             requests_by_kind[KIND_HEX], requests_by_kind[KIND_PTR]);
    $display("covered: %0d characters compared, %0d errors, %0d cycles",
             chars_checked, error_count, cycle_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
